// ----- sv/twp_pkg.sv -----
// turbulent texcoord warp: shared types, register codes and constants
// sine table contents are built here at elaboration from a fixed-point series
// depends on nothing
`timescale 1ns / 1ps

package twp_pkg;

    // sine table, must stay a power of two so the index is a bit field
    localparam int SINE_TABLE_SIZE = 128;
    localparam int SINE_IDX_W      = $clog2(SINE_TABLE_SIZE);

    // apb register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_WARP_MODE = 1'b0;
    localparam logic REG_TIME_NOW  = 1'b1;

    // warp modes
    localparam logic WARP_WATER   = 1'b0;
    localparam logic WARP_CAUSTIC = 1'b1;

    // field widths
    localparam int COORD_W = 24;
    localparam int OUT_W   = 32;
    localparam int TIME_W  = 32;
    localparam int PHASE_W = 34;
    localparam int TURNS_W = 48;
    localparam int FRAC_W  = 16;
    localparam int LERP_W  = 24;
    localparam int QUOT_W  = 21;

    // phase to turns, round(2^32 / 2pi) and round(2^32 * 0.465 / 2pi)
    localparam int RATE_W = 30;
    localparam logic [RATE_W-1:0] RATE_WATER   = 30'd683565276;
    localparam logic [RATE_W-1:0] RATE_CAUSTIC = 30'd317857853;

    // divide by 255 via reciprocal, exact for 32-bit dividends
    localparam logic [31:0] DIV255_MAGIC = 32'h8080_8081;
    localparam int DIV255_SHIFT = 39;

    // accept to result strobe, in cycles
    localparam int PIPE_LAT = 5;

    localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
    localparam logic [63:0] ONE_Q31     = 64'h8000_0000;

    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] time_now;
    } cfg_t;

    // one series term step: term * x^2 / (a * b), all Q31
    function automatic logic [63:0] sin_q31(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        term = x;
        sum  = x;
        term = ((term * x) >> 31) / 2;
        term = ((term * x) >> 31) / 3;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x) >> 31) / 4;
        term = ((term * x) >> 31) / 5;
        sum  = sum + term;
        term = ((term * x) >> 31) / 6;
        term = ((term * x) >> 31) / 7;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x) >> 31) / 8;
        term = ((term * x) >> 31) / 9;
        sum  = sum + term;
        term = ((term * x) >> 31) / 10;
        term = ((term * x) >> 31) / 11;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x) >> 31) / 12;
        term = ((term * x) >> 31) / 13;
        sum  = sum + term;
        term = ((term * x) >> 31) / 14;
        term = ((term * x) >> 31) / 15;
        sum  = (sum >= term) ? sum - term : 64'd0;
        return (sum > ONE_Q31) ? ONE_Q31 : sum;
    endfunction

    // table entry i: 255 * (1 + sin) / 2 from a quarter-wave series
    function automatic logic [7:0] sine_entry(input int i);
        logic [63:0] n;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] scaled;
        logic        neg;
        n   = 64'(4 * i);
        neg = 1'b0;
        if (n >= 64'(2 * SINE_TABLE_SIZE))
        begin
            neg = 1'b1;
            n   = n - 64'(2 * SINE_TABLE_SIZE);
        end
        if (n > 64'(SINE_TABLE_SIZE))
        begin
            n = 64'(2 * SINE_TABLE_SIZE) - n;
        end
        if (n == 64'd0)
        begin
            s = 64'd0;
        end
        else if (n == 64'(SINE_TABLE_SIZE))
        begin
            s = ONE_Q31;
        end
        else
        begin
            s = sin_q31((HALF_PI_Q31 * n) / SINE_TABLE_SIZE);
        end
        v      = neg ? ONE_Q31 - s : ONE_Q31 + s;
        scaled = (64'd255 * v) >> 32;
        return scaled[7:0];
    endfunction

endpackage

// ----- sv/twp_cfg_regs.sv -----
// apb register block: warp mode and frame time
// depends on twp_pkg
`timescale 1ns / 1ps

module twp_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [twp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [twp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [twp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output twp_pkg::cfg_t                  cfg
);

    logic                       mode_reg;
    logic                       mode_next;
    logic [twp_pkg::TIME_W-1:0] time_reg;
    logic [twp_pkg::TIME_W-1:0] time_next;
    logic                       wr_en;
    logic                       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    // word address, low two bits ignored
    assign reg_idx = paddr[2];

    always_comb
    begin
        mode_next = mode_reg;
        time_next = time_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                twp_pkg::REG_WARP_MODE: mode_next = pwdata[0];
                twp_pkg::REG_TIME_NOW:  time_next = pwdata[twp_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            twp_pkg::REG_WARP_MODE: prdata = {31'd0, mode_reg};
            twp_pkg::REG_TIME_NOW:  prdata = time_reg;
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= twp_pkg::WARP_WATER;
            time_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            time_reg <= time_next;
        end
    end

    assign cfg.mode     = mode_reg;
    assign cfg.time_now = time_reg;

endmodule

// ----- sv/twp_wave_lane.sv -----
// one coordinate lane: phase, turns multiply, sine lerp, divide by 255, scale
// five register stages, payload only; valid bits live in the core
// depends on twp_pkg
`timescale 1ns / 1ps

module twp_wave_lane
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  twp_pkg::cfg_t                       cfg,
    input  logic signed [twp_pkg::COORD_W-1:0]  own,
    input  logic signed [twp_pkg::COORD_W-1:0]  other,
    input  logic                                out_en,
    output logic signed [twp_pkg::OUT_W-1:0]    warped
);

    localparam int IW = twp_pkg::SINE_IDX_W;
    localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
    localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

    // constant sine table
    logic [7:0] sine_rom [twp_pkg::SINE_TABLE_SIZE];

    for (genvar g = 0; g < twp_pkg::SINE_TABLE_SIZE; g++)
    begin : g_rom
        assign sine_rom[g] = twp_pkg::sine_entry(g);
    end

    // stage 1: phase in q16.16
    logic signed [twp_pkg::PHASE_W-1:0] phase_reg;
    logic signed [twp_pkg::PHASE_W-1:0] phase_next;
    logic signed [twp_pkg::COORD_W-1:0] own1_reg;
    logic signed [twp_pkg::PHASE_W-1:0] time_ext;

    assign time_ext = $signed({2'b00, cfg.time_now});

    always_comb
    begin
        if (cfg.mode == twp_pkg::WARP_CAUSTIC)
        begin
            phase_next = (twp_pkg::PHASE_W'(other) <<< 8) + time_ext;
        end
        else
        begin
            phase_next = (twp_pkg::PHASE_W'(other) <<< 5) + time_ext;
        end
    end

    // stage 2: turns, wraps modulo a whole turn
    logic [twp_pkg::TURNS_W-1:0]      turns_reg;
    logic signed [twp_pkg::COORD_W-1:0] own2_reg;
    logic [twp_pkg::RATE_W-1:0]       rate;
    logic signed [twp_pkg::RATE_W:0]  rate_s;
    logic signed [64:0]               turns_prod;

    assign rate       = (cfg.mode == twp_pkg::WARP_CAUSTIC) ? twp_pkg::RATE_CAUSTIC
                                                           : twp_pkg::RATE_WATER;
    assign rate_s     = $signed({1'b0, rate});
    assign turns_prod = phase_reg * rate_s;

    // stage 3: table lookup and linear interpolation
    logic [IW-1:0]                 idx;
    logic [IW-1:0]                 idx_nxt;
    logic [twp_pkg::FRAC_W-1:0]    frac;
    logic [twp_pkg::FRAC_W:0]      frac_inv;
    logic [7:0]                    rom_a;
    logic [7:0]                    rom_b;
    logic [24:0]                   lerp_sum;
    logic [twp_pkg::LERP_W-1:0]    lerp_reg;
    logic signed [twp_pkg::COORD_W-1:0] own3_reg;

    assign idx      = turns_reg[twp_pkg::TURNS_W-1 -: IW];
    assign idx_nxt  = idx + 1'b1;
    assign frac     = turns_reg[twp_pkg::TURNS_W-1-IW -: twp_pkg::FRAC_W];
    assign frac_inv = 17'h10000 - {1'b0, frac};
    assign rom_a    = sine_rom[idx];
    assign rom_b    = sine_rom[idx_nxt];
    assign lerp_sum = rom_a * frac_inv + rom_b * {1'b0, frac};

    // stage 4: 16 * lerp / 255
    logic [59:0]                   div_prod;
    logic [twp_pkg::QUOT_W-1:0]    quot_reg;
    logic signed [twp_pkg::COORD_W-1:0] own4_reg;

    assign div_prod = {lerp_reg, 4'b0000} * twp_pkg::DIV255_MAGIC;

    // stage 5: add wave, scale, floor, saturate
    logic signed [21:0]            wave;
    logic signed [32:0]            sum;
    logic signed [34:0]            sum35;
    logic signed [34:0]            tri_sum;
    logic signed [34:0]            scaled;
    logic signed [twp_pkg::OUT_W-1:0] warped_reg;
    logic signed [twp_pkg::OUT_W-1:0] warped_next;

    assign wave    = $signed({1'b0, quot_reg}) - 22'sd524288;
    assign sum     = 33'($signed({own4_reg, 8'h00})) + 33'(wave);
    assign sum35   = 35'(sum);
    assign tri_sum = sum35 + (sum35 <<< 1);

    always_comb
    begin
        if (cfg.mode == twp_pkg::WARP_CAUSTIC)
        begin
            scaled = (-tri_sum) >>> 7;
        end
        else
        begin
            scaled = sum35 >>> 6;
        end
        if (scaled > SAT_MAX)
        begin
            warped_next = SAT_MAX[twp_pkg::OUT_W-1:0];
        end
        else if (scaled < SAT_MIN)
        begin
            warped_next = SAT_MIN[twp_pkg::OUT_W-1:0];
        end
        else
        begin
            warped_next = scaled[twp_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        own1_reg  <= own;
        turns_reg <= turns_prod[twp_pkg::TURNS_W-1:0];
        own2_reg  <= own1_reg;
        lerp_reg  <= lerp_sum[twp_pkg::LERP_W-1:0];
        own3_reg  <= own2_reg;
        quot_reg  <= div_prod[twp_pkg::DIV255_SHIFT +: twp_pkg::QUOT_W];
        own4_reg  <= own3_reg;
    end

    // result register holds between transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warped_reg <= '0;
        end
        else if (out_en)
        begin
            warped_reg <= warped_next;
        end
    end

    assign warped = warped_reg;

endmodule

// ----- sv/turbulent_texcoord_warp_core.sv -----
// top level of the turbulent texture coordinate warp
// instantiates twp_cfg_regs and two twp_wave_lane, uses twp_pkg
`timescale 1ns / 1ps

// One vertex per clock: a transaction is taken whenever start is high, busy is
// always low. The warped pair appears on warped_s / warped_t with done high for
// exactly one cycle, once the accepted transaction has passed every stage and has
// been captured by the result registers of both lanes. The five stages
// are phase add, phase-to-turns multiply, sine table lerp, reciprocal divide by
// 255, and final scale with saturation; each lane owns its own multipliers and
// sine table, so there is no shared resource and no stall. Results cannot be
// held off, so collect them on the cycle done is high. warp_mode and time_now
// are read live by the stages, so write them only while no transaction is in
// flight (write edge no earlier than the edge that raises done for the last one).
module turbulent_texcoord_warp_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // apb configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [twp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [twp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [twp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // vertex command
    input  logic                                start,
    output logic                                busy,
    input  logic signed [twp_pkg::COORD_W-1:0]  base_s,
    input  logic signed [twp_pkg::COORD_W-1:0]  base_t,
    // result strobe
    output logic                                done,
    output logic signed [twp_pkg::OUT_W-1:0]    warped_s,
    output logic signed [twp_pkg::OUT_W-1:0]    warped_t
);

    localparam int LAT = twp_pkg::PIPE_LAT;

    twp_pkg::cfg_t  cfg;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           accept;
    logic           out_en;

    // configuration registers
    twp_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // fully pipelined, never backs up
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // valid bits ride alongside the lane payload
    assign vld_next = {vld_reg[LAT-2:0], accept};
    assign out_en   = vld_reg[LAT-2];
    assign done     = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // s is warped by a wave driven from t, and t by a wave driven from s
    twp_wave_lane u_lane_s
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .own    (base_s),
        .other  (base_t),
        .out_en (out_en),
        .warped (warped_s)
    );

    twp_wave_lane u_lane_t
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .own    (base_t),
        .other  (base_s),
        .out_en (out_en),
        .warped (warped_t)
    );

    // every accepted transaction produces its strobe after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("accepted transaction did not produce a result strobe");

    // result ports only change when a new result is strobed
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> ($stable(warped_s) && $stable(warped_t)))
        else $error("result ports changed without a strobe");

    // mode register reads back as a single bit
    a_mode_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (paddr[2] == twp_pkg::REG_WARP_MODE) |-> (prdata[31:1] == 31'd0))
        else $error("mode register read back with stray bits");

endmodule
